// File: design/fsf_pkg.sv
// ----------------------------------------------------------------------------
// fsf_pkg: shared types and constants for the framebuffer shape fill block
// Command and result request formats, operation codes and canvas limits.
// ----------------------------------------------------------------------------
package fsf_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COLOR_BITS = 32;
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_RECT   = 3'd1;
  localparam logic [2:0] OP_CIRCLE = 3'd2;
  localparam logic [2:0] OP_LINE   = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic [31:0]        fill_color;
  } fsf_in_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic        read_outside;
  } fsf_out_t;

endpackage

// File: design/fsf_ram.sv
// ----------------------------------------------------------------------------
// fsf_ram: generic single port RAM
// One write or one read a cycle, registered read data.
// ----------------------------------------------------------------------------
module fsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/framebuffer_shape_fill.sv
// ----------------------------------------------------------------------------
// framebuffer_shape_fill: rectangle, circle and line rasteriser with store
// Walks each fill command's clipped box one pixel a cycle; a line, one column a cycle.
// ----------------------------------------------------------------------------
// channel | ports                         | handshake
// in      | in_start, in_busy, in_request | start high, busy low
// out     | out_strobe, out_request       | one cycle, no stall
// cfg     | cfg_we, cfg_index, cfg_data   | write on we
// After reset a clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT words with busy high.
// A shape passes a setup state, then walks its clipped box pixel by pixel; a line
// first runs a bit-serial slope divider, then walks only its clipped columns.
// A read is busy in SETUP, RD and RES and strobes in the cycle after. Reset is synchronous.
// The receiver cannot stall; a result shows for one cycle only.
// ----------------------------------------------------------------------------
module framebuffer_shape_fill (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_start,
  output logic                       in_busy,
  input  fsf_pkg::fsf_in_t           in_request,
  output logic                       out_strobe,
  output fsf_pkg::fsf_out_t          out_request,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [8:0]                 cfg_data
);
  import fsf_pkg::*;

  typedef enum logic [6:0] {
    S_WIPE  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SETUP = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_WALK  = 7'b0010000,
    S_RD    = 7'b0100000,
    S_RES   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [8:0] cw_r, ch_r;
  logic [9:0] aw, ah;
  fsf_in_t cmd_r;
  logic [AW:0] wipe_r;
  logic signed [17:0] x0_r, x1_r, y0_r, y1_r, x_r, y_r;
  logic signed [33:0] rr_r;
  // line divider
  logic [47:0] rem_r;
  logic [47:0] quo_r, dvd;
  logic [16:0] den_r;
  logic        neg_r;
  logic [5:0]  cnt_r;
  logic signed [47:0] m_r, yq_r;
  logic        outside_r;

  assign aw = (cw_r > 9'(MAX_WIDTH))  ? 10'(MAX_WIDTH)  : {1'b0, cw_r};
  assign ah = (ch_r > 9'(MAX_HEIGHT)) ? 10'(MAX_HEIGHT) : {1'b0, ch_r};

  function automatic logic signed [17:0] clampv(logic signed [17:0] v, logic [9:0] hi);
    logic signed [17:0] h;
    h = $signed({8'd0, hi});
    return v < 0 ? 18'sd0 : (v > h ? h : v);
  endfunction

  logic signed [17:0] ax, ay, bx, by;
  assign ax = 18'(cmd_r.first_x);
  assign ay = 18'(cmd_r.first_y);
  assign bx = 18'(cmd_r.second_x);
  assign by = 18'(cmd_r.second_y);

  // per-pixel test
  logic signed [17:0] ddx, ddy, ly;
  logic signed [35:0] dist_sq;
  logic on_canvas, hit;
  assign ddx = ax - x_r;
  assign ddy = ay - y_r;
  assign dist_sq = 36'(ddx * ddx) + 36'(ddy * ddy);
  assign ly = 18'((yq_r < 0 ? -((-yq_r) >>> 16) : (yq_r >>> 16)));
  always_comb begin
    hit = 1'b1;
    if (cmd_r.operation == OP_CIRCLE) hit = dist_sq < 36'(rr_r);
    on_canvas = 1'b1;
    if (cmd_r.operation == OP_LINE)
      on_canvas = !(ly < 0) && (ly < $signed({8'd0, ah}));
  end

  logic [XW-1:0] px;
  logic [YW-1:0] py;
  logic we;
  logic [AW-1:0] addr;
  logic [31:0] wdata, rdata;
  assign px = XW'(x_r);
  assign py = (cmd_r.operation == OP_LINE) ? YW'(ly) : YW'(y_r);

  always_comb begin
    we = 1'b0;
    addr = {py, px};
    wdata = cmd_r.fill_color & 32'((64'd1 << COLOR_BITS) - 64'd1);
    case (state_r)
      S_WIPE: begin
        we = 1'b1;
        addr = wipe_r[AW-1:0];
        wdata = '0;
      end
      S_WALK: we = hit && on_canvas && (x_r < x1_r) && (y_r < y1_r);
      S_RD, S_RES: addr = {YW'(ay), XW'(ax)};
      default: ;
    endcase
  end

  fsf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic signed [16:0] ldx, ldy;
  assign ldx = 17'(cmd_r.second_x) - 17'(cmd_r.first_x);
  assign ldy = 17'(cmd_r.second_y) - 17'(cmd_r.first_y);
  assign dvd = 48'(ldy < 0 ? -ldy : ldy) << 16;

  logic [48:0] trial;
  assign trial = {rem_r, quo_r[47]};

  function automatic logic signed [47:0] m_final();
    logic [47:0] q;
    q = {quo_r[46:0], trial >= {32'd0, den_r}};
    return neg_r ? -$signed(q) : $signed(q);
  endfunction

  logic signed [33:0] m_lo;
  logic signed [17:0] x_off;
  logic signed [51:0] m_prod;
  assign m_lo = 34'(m_final());
  assign x_off = x0_r - ax;
  assign m_prod = m_lo * x_off;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WIPE;
      wipe_r  <= '0;
      cw_r    <= 9'd256;
      ch_r    <= 9'd256;
      out_strobe <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_strobe <= state_r == S_RES;
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  cw_r <= cfg_data;
          REG_HEIGHT: ch_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_WIPE) wipe_r <= wipe_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_WIPE: if (wipe_r == (AW+1)'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_start) state_nxt = S_SETUP;
      S_SETUP: begin
        case (cmd_r.operation)
          OP_READ: state_nxt = S_RD;
          OP_LINE: state_nxt = (ldx == 0) ? S_IDLE : S_DIV;
          OP_CLEAR, OP_RECT, OP_CIRCLE: state_nxt = S_WALK;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_DIV: if (cnt_r == 6'd0) state_nxt = S_WALK;
      S_WALK: if (x_r >= x1_r - 1 && (y_r >= y1_r - 1 || cmd_r.operation == OP_LINE)
                  || x0_r >= x1_r || y0_r >= y1_r) state_nxt = S_IDLE;
      S_RD: state_nxt = S_RES;
      S_RES: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_start) cmd_r <= in_request;
    case (state_r)
      S_SETUP: begin
        outside_r <= ax < 0 || ay < 0 || ax >= $signed({8'd0, aw}) ||
                     ay >= $signed({8'd0, ah});
        rr_r <= 34'(bx * bx);
        den_r <= 17'(ldx < 0 ? -ldx : ldx);
        neg_r <= (ldx < 0) != (ldy < 0);
        quo_r <= dvd;
        rem_r <= '0;
        cnt_r <= 6'd47;
        case (cmd_r.operation)
          OP_CLEAR: begin
            x0_r <= 0; y0_r <= 0;
            x1_r <= $signed({8'd0, aw}); y1_r <= $signed({8'd0, ah});
          end
          OP_RECT: begin
            x0_r <= clampv(ax, aw); x1_r <= clampv(ax + bx, aw);
            y0_r <= clampv(ay, ah); y1_r <= clampv(ay + by, ah);
          end
          OP_CIRCLE: begin
            x0_r <= clampv(ax - bx, aw); x1_r <= clampv(ax + bx, aw);
            y0_r <= clampv(ay - bx, ah); y1_r <= clampv(ay + bx, ah);
          end
          default: begin
            x0_r <= clampv(ldx < 0 ? bx : ax, aw);
            x1_r <= clampv((ldx < 0 ? bx : ax) + 18'(ldx < 0 ? -ldx : ldx), aw);
            y0_r <= 0; y1_r <= 1;
          end
        endcase
      end
      S_DIV: begin
        if (trial >= {32'd0, den_r}) rem_r <= 48'(trial - {32'd0, den_r});
        else rem_r <= trial[47:0];
        quo_r <= {quo_r[46:0], trial >= {32'd0, den_r}};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd0) begin
          m_r <= neg_r ? -$signed({quo_r[46:0], trial >= {32'd0, den_r}})
                       :  $signed({quo_r[46:0], trial >= {32'd0, den_r}});
        end
      end
      default: ;
    endcase
    if (state_nxt == S_WALK && state_r != S_WALK) begin
      x_r <= (state_r == S_DIV) ? x0_r : ((cmd_r.operation == OP_CLEAR) ? 18'sd0
             : (cmd_r.operation == OP_RECT ? clampv(ax, aw)
             : clampv(ax - bx, aw)));
      y_r <= (state_r == S_DIV) ? 18'sd0 : ((cmd_r.operation == OP_CLEAR) ? 18'sd0
             : (cmd_r.operation == OP_RECT ? clampv(ay, ah)
             : clampv(ay - bx, ah)));
      if (state_r == S_DIV)
        yq_r <= 48'(m_prod) + (48'(ay) <<< 16);
    end else if (state_r == S_WALK) begin
      if (x_r >= x1_r - 1) begin
        x_r <= x0_r;
        y_r <= y_r + 1;
      end else begin
        x_r <= x_r + 1;
      end
      yq_r <= yq_r + m_r;
    end
  end

  assign in_busy = state_r != S_IDLE;
  assign out_request.pixel_value  = outside_r ? 32'd0 : rdata;
  assign out_request.read_outside = outside_r;

  a_strobe_after_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r) == S_RES) else $error("stray strobe");
  a_busy_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_start) |=> in_busy) else $error("no busy");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !we) else $error("idle write");

endmodule
